FILE: rtl/adc_smoothing_window_average_assert.svh
// assertion macros for the smoothing window average block
// used by the top level only, no other dependencies
`ifndef ADC_SMOOTHING_WINDOW_AVERAGE_ASSERT_SVH
`define ADC_SMOOTHING_WINDOW_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ASW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("asw assertion failed");

// next-cycle implication, disabled while reset is low
`define ASW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("asw assertion failed");

`endif

FILE: rtl/asw_pkg.sv
// shared constants and types for the smoothing window average block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package asw_pkg;

    localparam int THRESH_W     = 10;
    localparam int THRESH_RESET = 40;
    localparam int SMOOTH_RESET = 10;

    typedef logic [THRESH_W-1:0] t_threshold;

endpackage

`default_nettype wire

FILE: rtl/asw_if.sv
// channel interfaces: sample input, result output, threshold write
// depends on asw_pkg
`timescale 1ns / 1ps
`default_nettype none

interface asw_sample_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface asw_result_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] smoothed_value;
    logic [SAMPLE_BITS-1:0] window_average;
    logic                   big_change;

    modport source (output valid, output smoothed_value, output window_average,
                    output big_change, input ready);
    modport sink   (input valid, input smoothed_value, input window_average,
                    input big_change, output ready);
endinterface

interface asw_cfg_if;
    logic                 valid;
    logic                 ready;
    asw_pkg::t_threshold  change_threshold;

    modport source (output valid, output change_threshold, input ready);
    modport sink   (input valid, input change_threshold, output ready);
endinterface

`default_nettype wire

FILE: rtl/asw_ring.sv
// history ring: one write and one registered read per cycle
// per-entry valid bits so unwritten entries read as zero; no package use
`timescale 1ns / 1ps
`default_nettype none

module asw_ring #(
    parameter int DEPTH  = 40,
    parameter int DATA_W = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: rtl/adc_smoothing_window_average.sv
// top level: halving smoother, history ring, running sum and window average
// depends on asw_pkg, asw_if, asw_ring and the assertion header
//
//  channel      dir  transaction payload
//  i_sample_ch  in   sample
//  o_result_ch  out  smoothed_value, window_average, big_change
//  i_cfg_ch     in   change_threshold (always ready)
//
// one transaction per clock sustained while o_result_ch.ready is high; registered in stage one, then stage two
// first stage: smoother, ring read/write, sum update and change compare
// second stage: reciprocal multiply for the average, result register
// stalls ripple back through both stages; nothing is dropped
// reset clears the ring valid bits at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

`include "adc_smoothing_window_average_assert.svh"

module adc_smoothing_window_average #(
    parameter int WINDOW_DEPTH = 40,
    parameter int SAMPLE_BITS  = 10
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    asw_sample_if.sink    i_sample_ch,
    asw_result_if.source  o_result_ch,
    asw_cfg_if.sink       i_cfg_ch
);

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int CMP_W  = (SAMPLE_BITS > asw_pkg::THRESH_W) ? SAMPLE_BITS
                                                              : asw_pkg::THRESH_W;
    localparam int RCP_SH = SUM_W + IDX_W;
    localparam int RCP_W  = SUM_W + 2;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << RCP_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);

    // configuration
    asw_pkg::t_threshold r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= asw_pkg::t_threshold'(asw_pkg::THRESH_RESET);
        end else if (i_cfg_ch.valid) begin
            r_threshold <= i_cfg_ch.change_threshold;
        end
    end

    assign i_cfg_ch.ready = 1'b1;

    // state
    logic [SAMPLE_BITS-1:0] r_smoothed;
    logic [IDX_W-1:0]       r_widx;
    logic [SUM_W-1:0]       r_sum;

    // stage registers
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_s1_smoothed;
    logic [SUM_W-1:0]       r_s1_sum;
    logic                   r_s1_big;
    logic                   r_s2_valid;
    logic [SAMPLE_BITS-1:0] r_s2_smoothed;
    logic [SAMPLE_BITS-1:0] r_s2_avg;
    logic                   r_s2_big;

    logic                   accept;
    logic                   s1_go;
    logic [SAMPLE_BITS:0]   smooth_add;
    logic [SAMPLE_BITS-1:0] n_smoothed;
    logic [SAMPLE_BITS-1:0] old_entry;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   n_big;
    logic [SUM_W-1:0]       n_sum;
    logic [IDX_W-1:0]       n_widx;
    logic [IDX_W-1:0]       rd_addr;
    logic [PROD_W-1:0]      product;
    logic [SAMPLE_BITS-1:0] n_avg;
    logic                   n_s1_valid;
    logic                   n_s2_valid;

    assign s1_go              = r_s1_valid && (!r_s2_valid || o_result_ch.ready);
    assign i_sample_ch.ready  = !r_s1_valid || s1_go;
    assign accept             = i_sample_ch.valid && i_sample_ch.ready;

    assign smooth_add = {1'b0, r_smoothed} + {1'b0, i_sample_ch.sample};
    assign n_smoothed = smooth_add[SAMPLE_BITS:1];

    assign diff  = (old_entry > n_smoothed) ? (old_entry - n_smoothed)
                                            : (n_smoothed - old_entry);
    assign n_big = CMP_W'(diff) > CMP_W'(r_threshold);

    assign n_sum  = r_sum - SUM_W'(old_entry) + SUM_W'(n_smoothed);
    assign n_widx = (r_widx == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : r_widx + 1'b1;

    // read one entry ahead so the replaced value is ready when the item arrives
    assign rd_addr = accept ? n_widx : r_widx;

    asw_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .DATA_W (SAMPLE_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr_addr (r_widx),
        .i_wr_data (n_smoothed),
        .i_rd_addr (rd_addr),
        .o_rd_data (old_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothed <= SAMPLE_BITS'(asw_pkg::SMOOTH_RESET);
            r_widx     <= '0;
            r_sum      <= '0;
        end else if (accept) begin
            r_smoothed <= n_smoothed;
            r_widx     <= n_widx;
            r_sum      <= n_sum;
        end
    end

    // stage one
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_go) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_smoothed <= n_smoothed;
            r_s1_sum      <= n_sum;
            r_s1_big      <= n_big;
        end
    end

    // stage two: floor divide by window depth via reciprocal
    assign product = PROD_W'(r_s1_sum) * PROD_W'(RCP_W'(RECIP));
    assign n_avg   = product[RCP_SH +: SAMPLE_BITS];

    always_comb begin
        n_s2_valid = r_s2_valid;
        if (s1_go) begin
            n_s2_valid = 1'b1;
        end else if (o_result_ch.ready) begin
            n_s2_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_smoothed <= r_s1_smoothed;
            r_s2_avg      <= n_avg;
            r_s2_big      <= r_s1_big;
        end
    end

    assign o_result_ch.valid          = r_s2_valid;
    assign o_result_ch.smoothed_value = r_s2_smoothed;
    assign o_result_ch.window_average = r_s2_avg;
    assign o_result_ch.big_change     = r_s2_big;

    // checks
    `ASW_ASSERT_NEXT(a_accept_loads_s1, i_clk, i_rst_n, accept, r_s1_valid)
    `ASW_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_go && !accept,
        r_s1_valid && $stable(r_s1_sum) && $stable(r_s1_smoothed))
    `ASW_ASSERT_NEXT(a_s2_load, i_clk, i_rst_n, s1_go,
        o_result_ch.valid && (o_result_ch.smoothed_value == $past(r_s1_smoothed)))
    `ASW_ASSERT_NEXT(a_avg_floor, i_clk, i_rst_n, s1_go,
        (32'(o_result_ch.window_average) * WINDOW_DEPTH <= 32'($past(r_s1_sum))) &&
        (32'($past(r_s1_sum)) < (32'(o_result_ch.window_average) + 1) * WINDOW_DEPTH))

endmodule

`default_nettype wire
